[rtl/ray_triangle_intersect_macros.svh]
// Assertion macros used by the checker file.
`ifndef RAY_TRIANGLE_INTERSECT_MACROS_SVH
`define RAY_TRIANGLE_INTERSECT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define RTI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define RTI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[rtl/rti_pkg.sv]
// ----------------------------------------------------------------------------
// rti_pkg
// Shared types and constants of the ray-triangle intersection block.
// ----------------------------------------------------------------------------
package rti_pkg;
  localparam int CoordW  = 32;
  localparam int DistW   = 31;
  localparam int NumRegs = 8;
  localparam int AddrW   = 5;

  typedef enum logic [2:0] {
    RegOrgX = 3'd0, RegOrgY = 3'd1, RegOrgZ = 3'd2,
    RegDirX = 3'd3, RegDirY = 3'd4, RegDirZ = 3'd5,
    RegEps  = 3'd6, RegMinD = 3'd7
  } reg_idx_e;

  typedef logic signed [32:0]  diff_t;
  typedef logic signed [65:0]  prod_t;
  typedef logic signed [67:0]  cross_t;
  typedef logic signed [100:0] dot_t;
endpackage

[rtl/ray_triangle_intersect.sv]
// ----------------------------------------------------------------------------
// ray_triangle_intersect
// Moller-Trumbore ray-triangle test in exact fixed point.
// ----------------------------------------------------------------------------
// One triangle is accepted per clock cycle unless the pipeline is stalled.
// Eight arithmetic stages come first: the differences, the two halves of
// the cross products, the split partial products of the dot products, the
// dot product terms, their sums, the sign normalization and the bound tests.
// A divider follows with a load stage and one stage per quotient bit, 33
// stages in all, and then the output register. The stages are the same
// whatever the value of FRAC_BITS. The whole pipeline stalls while the
// result beat is not taken. The ray and the limits are APB registers; the
// user must see that they are written only while no triangle is in flight,
// since the block itself does not enforce it.
module ray_triangle_intersect #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [rti_pkg::AddrW-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (32 bits each)
  input  logic [287:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // hit (bit 0), distance (bits 31:1)
  output logic [31:0] m_axis_tdata
);
  import rti_pkg::*;

  localparam int QW   = 32;
  localparam int NumW = 101 + FRAC_BITS;

  // Configuration registers.
  logic signed [31:0] org_q [3];
  logic signed [31:0] dir_q [3];
  logic [31:0]        eps_q;
  logic [DistW-1:0]   mind_q;
  logic               wr;
  reg_idx_e           widx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign widx   = reg_idx_e'(paddr[AddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q  <= '{default: '0};
      dir_q  <= '{32'sd65536, 32'sd0, 32'sd0};
      eps_q  <= 32'd1;
      mind_q <= '0;
    end else if (wr) begin
      case (widx)
        RegOrgX: org_q[0] <= pwdata;
        RegOrgY: org_q[1] <= pwdata;
        RegOrgZ: org_q[2] <= pwdata;
        RegDirX: dir_q[0] <= pwdata;
        RegDirY: dir_q[1] <= pwdata;
        RegDirZ: dir_q[2] <= pwdata;
        RegEps:  eps_q    <= pwdata;
        RegMinD: mind_q   <= pwdata[DistW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      RegOrgX: prdata = org_q[0];
      RegOrgY: prdata = org_q[1];
      RegOrgZ: prdata = org_q[2];
      RegDirX: prdata = dir_q[0];
      RegDirY: prdata = dir_q[1];
      RegDirZ: prdata = dir_q[2];
      RegEps:  prdata = eps_q;
      RegMinD: prdata = {1'b0, mind_q};
      default: prdata = '0;
    endcase
  end

  // Pipeline enable: advance unless a result is held and not taken.
  logic en;
  logic out_vld_q;
  logic [31:0] out_q;
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // Stage 1: edge and origin differences.
  logic [7:0] v_q;
  diff_t e1_q [3], e2_q [3], sv_q [3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e1_q[i] <= diff_t'($signed(s_axis_tdata[32*(3+i) +: 32]))
                 - diff_t'($signed(s_axis_tdata[32*i +: 32]));
        e2_q[i] <= diff_t'($signed(s_axis_tdata[32*(6+i) +: 32]))
                 - diff_t'($signed(s_axis_tdata[32*i +: 32]));
        sv_q[i] <= diff_t'(org_q[i]) - diff_t'($signed(s_axis_tdata[32*i +: 32]));
      end
    end
  end

  // Stage 2: cross product partial products (one register per product).
  prod_t pa_q [3], pb_q [3], qa_q [3], qb_q [3];
  diff_t e1b_q [3], e2b_q [3], svb_q [3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pa_q[i] <= prod_t'(diff_t'(dir_q[(i+1)%3])) * prod_t'(e2_q[(i+2)%3]);
        pb_q[i] <= prod_t'(diff_t'(dir_q[(i+2)%3])) * prod_t'(e2_q[(i+1)%3]);
        qa_q[i] <= prod_t'(sv_q[(i+1)%3]) * prod_t'(e1_q[(i+2)%3]);
        qb_q[i] <= prod_t'(sv_q[(i+2)%3]) * prod_t'(e1_q[(i+1)%3]);
      end
      e1b_q <= e1_q; e2b_q <= e2_q; svb_q <= sv_q;
    end
  end

  // Stage 3: cross product differences.
  cross_t p_q [3], q_q [3];
  diff_t e1c_q [3], e2c_q [3], svc_q [3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p_q[i] <= cross_t'(pa_q[i]) - cross_t'(pb_q[i]);
        q_q[i] <= cross_t'(qa_q[i]) - cross_t'(qb_q[i]);
      end
      e1c_q <= e1b_q; e2c_q <= e2b_q; svc_q <= svb_q;
    end
  end

  // Stage 4: dot product partial products. Each cross product component is
  // split into a signed high half and an unsigned low half, so that every
  // multiplier stays near 33 by 35 bits.
  localparam int LoW = 34;
  typedef logic signed [67:0] part_t;

  function automatic part_t mul_hi(diff_t a, cross_t b);
    return part_t'(a) * part_t'($signed(b[67:LoW]));
  endfunction

  function automatic part_t mul_lo(diff_t a, cross_t b);
    return part_t'(a) * part_t'($signed({1'b0, b[LoW-1:0]}));
  endfunction

  part_t hdet_q [3], ldet_q [3], hnu_q [3], lnu_q [3];
  part_t hnv_q [3], lnv_q [3], hnt_q [3], lnt_q [3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        hdet_q[i] <= mul_hi(e1c_q[i], p_q[i]);
        ldet_q[i] <= mul_lo(e1c_q[i], p_q[i]);
        hnu_q[i]  <= mul_hi(svc_q[i], p_q[i]);
        lnu_q[i]  <= mul_lo(svc_q[i], p_q[i]);
        hnv_q[i]  <= mul_hi(diff_t'(dir_q[i]), q_q[i]);
        lnv_q[i]  <= mul_lo(diff_t'(dir_q[i]), q_q[i]);
        hnt_q[i]  <= mul_hi(e2c_q[i], q_q[i]);
        lnt_q[i]  <= mul_lo(e2c_q[i], q_q[i]);
      end
    end
  end

  // Stage 5: dot product terms.
  dot_t tdet_q [3], tnu_q [3], tnv_q [3], tnt_q [3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        tdet_q[i] <= (dot_t'(hdet_q[i]) <<< LoW) + dot_t'(ldet_q[i]);
        tnu_q[i]  <= (dot_t'(hnu_q[i]) <<< LoW) + dot_t'(lnu_q[i]);
        tnv_q[i]  <= (dot_t'(hnv_q[i]) <<< LoW) + dot_t'(lnv_q[i]);
        tnt_q[i]  <= (dot_t'(hnt_q[i]) <<< LoW) + dot_t'(lnt_q[i]);
      end
    end
  end

  // Stage 6: sums.
  dot_t det_q, nu_q, nv_q, nt_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      det_q <= tdet_q[0] + tdet_q[1] + tdet_q[2];
      nu_q  <= tnu_q[0] + tnu_q[1] + tnu_q[2];
      nv_q  <= tnv_q[0] + tnv_q[1] + tnv_q[2];
      nt_q  <= tnt_q[0] + tnt_q[1] + tnt_q[2];
    end
  end

  // Stage 7: sign normalization so that det is not negative.
  dot_t dn_q, un_q, vn_q, tn_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      dn_q <= det_q[100] ? -det_q : det_q;
      un_q <= det_q[100] ? -nu_q  : nu_q;
      vn_q <= det_q[100] ? -nv_q  : nv_q;
      tn_q <= det_q[100] ? -nt_q  : nt_q;
    end
  end

  // Stage 8: bound tests.
  logic            ok_q;
  logic [99:0]     dd_q;
  logic [99:0]     tt_q;
  dot_t            uv;
  assign uv = un_q + vn_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      ok_q <= (dn_q != '0) && (dn_q >= dot_t'({1'b0, eps_q}))
           && !un_q[100] && (un_q <= dn_q)
           && !vn_q[100] && (uv <= dn_q)
           && !tn_q[100] && (tn_q != '0);
      dd_q <= dn_q[99:0];
      tt_q <= tn_q[99:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[6:0], s_axis_tvalid};
    end
  end

  // Divider: t = Nt * 2^FRAC_BITS / det.
  logic          dv_vld, dv_ovf, dv_ok;
  logic [QW-1:0] dv_quo;
  logic [NumW-1:0] dnum;
  assign dnum = {1'b0, tt_q, {FRAC_BITS{1'b0}}};

  rti_divider #(.NumW(NumW), .DenW(100), .QW(QW), .TagW(1)) u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v_q[7]),
    .num_i(dnum), .den_i(ok_q ? dd_q : 100'd1), .tag_i(ok_q),
    .valid_o(dv_vld), .quo_o(dv_quo), .ovf_o(dv_ovf), .tag_o(dv_ok)
  );

  logic [DistW-1:0] dist_sat;
  logic             hit;
  assign dist_sat = (dv_ovf || dv_quo[QW-1]) ? {DistW{1'b1}} : dv_quo[DistW-1:0];
  assign hit      = dv_ok && (dist_sat > mind_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= hit ? {dist_sat, 1'b1} : 32'd0;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;
endmodule

[rtl/rti_divider.sv]
// ----------------------------------------------------------------------------
// rti_divider
// Pipelined restoring divider, one quotient bit per stage, with stall.
// ----------------------------------------------------------------------------
module rti_divider #(
  parameter int NumW = 117,
  parameter int DenW = 100,
  parameter int QW   = 32,
  parameter int TagW = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  input  logic [TagW-1:0] tag_i,
  output logic            valid_o,
  output logic [QW-1:0]   quo_o,
  output logic            ovf_o,
  output logic [TagW-1:0] tag_o
);
  // The high part of the numerator gives the overflow check: if it is
  // not below the divisor, the quotient has more than QW bits.
  localparam int RemW = DenW + 1;

  logic [QW:0]                vld_q;
  logic [RemW-1:0]            rem_q [QW+1];
  logic [QW-1:0]              low_q [QW+1];
  logic [QW-1:0]              quo_q [QW+1];
  logic [DenW-1:0]            den_q [QW+1];
  logic [TagW-1:0]            tag_q [QW+1];
  logic                       ovf_q [QW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QW-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= {{(RemW-(NumW-QW)){1'b0}}, num_i[NumW-1:QW]};
      low_q[0] <= num_i[QW-1:0];
      quo_q[0] <= '0;
      den_q[0] <= den_i;
      tag_q[0] <= tag_i;
      ovf_q[0] <= ({{(RemW-(NumW-QW)){1'b0}}, num_i[NumW-1:QW]} >= {1'b0, den_i});
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [RemW-1:0] sh;
    logic [RemW-1:0] sub;
    logic            ge;
    assign sh  = {rem_q[s][RemW-2:0], low_q[s][QW-1]};
    assign ge  = sh >= {1'b0, den_q[s]};
    assign sub = sh - {1'b0, den_q[s]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1] <= ge ? sub : sh;
        low_q[s+1] <= {low_q[s][QW-2:0], 1'b0};
        quo_q[s+1] <= {quo_q[s][QW-2:0], ge};
        den_q[s+1] <= den_q[s];
        tag_q[s+1] <= tag_q[s];
        ovf_q[s+1] <= ovf_q[s];
      end
    end
  end

  assign valid_o = vld_q[QW];
  assign quo_o   = quo_q[QW];
  assign ovf_o   = ovf_q[QW];
  assign tag_o   = tag_q[QW];
endmodule

[rtl/rti_checker.sv]
// ----------------------------------------------------------------------------
// rti_checker
// Port-level assertions for the ray-triangle intersection block.
// ----------------------------------------------------------------------------
`include "ray_triangle_intersect_macros.svh"
module rti_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);
  // A miss always reports zero distance.
  `RTI_ASSERT_IMP(a_miss_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata == 32'd0)
  // The input side only stalls while a result beat is held.
  `RTI_ASSERT_IMP(a_ready, clk_i, rst_ni, !s_axis_tready, m_axis_tvalid && !m_axis_tready)
  // A stalled beat is held.
  `RTI_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
endmodule

bind ray_triangle_intersect rti_checker u_rti_checker (
  .clk_i, .rst_ni, .s_axis_tready, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
